/* rtl/smtrf_pkg.sv */
// Shared constants and types for the SPI master transmit/receive FIFO core.
package smtrf_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_GET     = 2'd1;
  localparam logic [1:0] OP_DONE    = 2'd2;
  localparam logic [1:0] OP_REQUEST = 2'd3;

  localparam logic [7:0] FILLER_BYTE = 8'hFD;
  localparam logic [7:0] EMPTY_BYTE  = 8'hFE;

  localparam int LEVEL_W = 5;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] received_byte;
    logic       rcv_filler;
  } cmd_t;

  typedef struct packed {
    logic               shift_valid;
    logic [7:0]         shift_byte;
    logic [7:0]         read_byte;
    logic               rx_not_empty;
    logic               tx_accepted;
    logic               rx_dropped;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } res_t;

endpackage

/* rtl/smtrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module smtrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/smtrf_front.sv */
// Request intake: classify each request and hold it in a two-entry queue.
module smtrf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        in_received_byte,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output smtrf_pkg::cmd_t   cmd
);
  import smtrf_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.op            = in_operation;
    cls.data_byte     = in_data_byte;
    cls.received_byte = in_received_byte;
    cls.rcv_filler    = (in_received_byte == FILLER_BYTE);
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

/* rtl/smtrf_back.sv */
// Request execution: FIFO pointers, link state, FIFO RAMs and result register.
module smtrf_back #(
  parameter int FIFO_DEPTH = smtrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  smtrf_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output smtrf_pkg::res_t res
);
  import smtrf_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic               shift_valid;
    logic               shift_from_ram;
    logic [7:0]         shift_imm;
    logic               read_from_ram;
    logic [7:0]         read_imm;
    logic               rx_not_empty;
    logic               tx_accepted;
    logic               rx_dropped;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } mid_t;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    inc_ptr = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [CW-1:0] tx_cnt_r, tx_cnt_nxt, rx_cnt_r, rx_cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          req_en_r, req_en_nxt;
  logic          m_valid_r, m_valid_nxt;
  mid_t          m_r, m_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r, res_nxt;

  logic          issue, m_move, out_free;
  logic          tx_we, tx_re, rx_we, rx_re;
  logic [7:0]    tx_rdata, rx_rdata;

  assign out_free  = !out_valid_r || !res_stall;
  assign m_move    = m_valid_r && out_free;
  assign cmd_ready = !m_valid_r || m_move;
  assign issue     = cmd_valid && cmd_ready;

  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_cnt_nxt  = tx_cnt_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    rx_cnt_nxt  = rx_cnt_r;
    busy_nxt    = busy_r;
    req_en_nxt  = req_en_r;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    m_nxt       = '0;
    if (issue) begin
      case (cmd.op)
        OP_SEND: begin
          req_en_nxt = 1'b0;
          if (tx_cnt_r < CW'(FIFO_DEPTH)) begin
            tx_we             = 1'b1;
            tx_tail_nxt       = inc_ptr(tx_tail_r);
            tx_cnt_nxt        = tx_cnt_r + CW'(1);
            m_nxt.tx_accepted = 1'b1;
          end
          if (tx_cnt_r == '0 && !busy_r) begin
            tx_head_nxt       = inc_ptr(tx_head_r);
            tx_cnt_nxt        = tx_cnt_r;
            busy_nxt          = 1'b1;
            m_nxt.shift_valid = 1'b1;
            m_nxt.shift_imm   = cmd.data_byte;
          end
        end
        OP_GET: begin
          if (rx_cnt_r != '0) begin
            rx_re               = 1'b1;
            rx_head_nxt         = inc_ptr(rx_head_r);
            rx_cnt_nxt          = rx_cnt_r - CW'(1);
            m_nxt.read_from_ram = 1'b1;
          end else begin
            m_nxt.read_imm = EMPTY_BYTE;
          end
        end
        OP_DONE: begin
          if (!cmd.rcv_filler) begin
            if (rx_cnt_r < CW'(FIFO_DEPTH)) begin
              rx_we       = 1'b1;
              rx_tail_nxt = inc_ptr(rx_tail_r);
              rx_cnt_nxt  = rx_cnt_r + CW'(1);
            end else begin
              m_nxt.rx_dropped = 1'b1;
            end
          end
          if (tx_cnt_r == '0) begin
            req_en_nxt = 1'b1;
            busy_nxt   = 1'b0;
          end else begin
            busy_nxt             = 1'b1;
            tx_re                = 1'b1;
            tx_head_nxt          = inc_ptr(tx_head_r);
            tx_cnt_nxt           = tx_cnt_r - CW'(1);
            m_nxt.shift_valid    = 1'b1;
            m_nxt.shift_from_ram = 1'b1;
          end
        end
        OP_REQUEST: begin
          if (req_en_r) begin
            m_nxt.shift_valid = 1'b1;
            if (tx_cnt_r != '0) begin
              tx_re                = 1'b1;
              tx_head_nxt          = inc_ptr(tx_head_r);
              tx_cnt_nxt           = tx_cnt_r - CW'(1);
              m_nxt.shift_from_ram = 1'b1;
            end else begin
              m_nxt.shift_imm = FILLER_BYTE;
            end
          end
        end
        default: begin
          m_nxt = '0;
        end
      endcase
      m_nxt.rx_not_empty = (rx_cnt_nxt != '0);
      m_nxt.tx_level     = LEVEL_W'(tx_cnt_nxt);
      m_nxt.rx_level     = LEVEL_W'(rx_cnt_nxt);
    end
  end

  always_comb begin
    m_valid_nxt = m_valid_r;
    if (issue) begin
      m_valid_nxt = 1'b1;
    end else if (m_move) begin
      m_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (m_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !res_stall) begin
      out_valid_nxt = 1'b0;
    end
    res_nxt.shift_valid  = m_r.shift_valid;
    res_nxt.shift_byte   = m_r.shift_from_ram ? tx_rdata : m_r.shift_imm;
    res_nxt.read_byte    = m_r.read_from_ram ? rx_rdata : m_r.read_imm;
    res_nxt.rx_not_empty = m_r.rx_not_empty;
    res_nxt.tx_accepted  = m_r.tx_accepted;
    res_nxt.rx_dropped   = m_r.rx_dropped;
    res_nxt.tx_level     = m_r.tx_level;
    res_nxt.rx_level     = m_r.rx_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_cnt_r    <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_cnt_r    <= '0;
      busy_r      <= 1'b0;
      req_en_r    <= 1'b1;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      busy_r      <= busy_nxt;
      req_en_r    <= req_en_nxt;
      m_valid_r   <= m_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_r <= m_nxt;
    end
    if (m_move) begin
      res_r <= res_nxt;
    end
  end

  smtrf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail_r),
    .wdata (cmd.data_byte),
    .re    (tx_re),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  smtrf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail_r),
    .wdata (cmd.received_byte),
    .re    (rx_re),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  assign res_valid = out_valid_r;
  assign res       = res_r;

  a_tx_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    tx_re |-> tx_cnt_r != '0)
    else $error("transmit RAM read with empty FIFO");

  a_tx_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r == '0 |-> tx_head_r == tx_tail_r)
    else $error("transmit pointers disagree with empty count");

  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(issue && cmd.op == OP_DONE))
    else $error("link went idle without transfer done");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(m_valid_r))
    else $error("result appeared without a request in flight");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.rx_dropped |-> res_r.rx_level == LEVEL_W'(FIFO_DEPTH))
    else $error("receive byte dropped while FIFO not full");

endmodule

/* rtl/spi_master_tx_rx_fifo_core.sv */
// Top level of the SPI master transmit/receive FIFO core.
// Each request (send, get, transfer done, slave request) yields exactly one result.
// Requests enter a two-entry queue, then the execution stage updates the FIFO
// pointers and reads the FIFO RAM, and the result lands in an output register.
// Sustained rate is one request per clock while out_stall is low. Each result
// passes through the queue, the execution stage register and the output register.
// Both FIFOs hold FIFO_DEPTH bytes; levels are reported in 5 bits. There is no
// clearing pass after reset.
module spi_master_tx_rx_fifo_core #(
  parameter int FIFO_DEPTH = smtrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_received_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_shift_valid,
  output logic [7:0] out_shift_byte,
  output logic [7:0] out_read_byte,
  output logic       out_rx_not_empty,
  output logic       out_tx_accepted,
  output logic       out_rx_dropped,
  output logic [4:0] out_tx_level,
  output logic [4:0] out_rx_level
);
  import smtrf_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  smtrf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_byte     (in_data_byte),
    .in_received_byte (in_received_byte),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd)
  );

  smtrf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign out_shift_valid  = res.shift_valid;
  assign out_shift_byte   = res.shift_byte;
  assign out_read_byte    = res.read_byte;
  assign out_rx_not_empty = res.rx_not_empty;
  assign out_tx_accepted  = res.tx_accepted;
  assign out_rx_dropped   = res.rx_dropped;
  assign out_tx_level     = res.tx_level;
  assign out_rx_level     = res.rx_level;

endmodule
